/* src/poc_pkg.sv */
package poc_pkg;

    // Field widths of the words on the ports.
    localparam int unsigned OP_W    = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned LEN_W   = 9;
    localparam int unsigned COUNT_W = 32;

    // Default depth of the pattern and window rows.
    localparam int unsigned MAX_PATTERN_DEF = 256;

    // Number of cell compare bits that one group register folds together.
    localparam int unsigned GROUP_SIZE = 32;

    // The byte counter since the last match stops at this value.
    localparam logic [LEN_W-1:0] SINCE_MAX = {LEN_W{1'b1}};

    // The occurrence total stops at this value.
    localparam logic [COUNT_W-1:0] TOTAL_MAX = {COUNT_W{1'b1}};

    // Operation codes of an input word.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_SEARCH  = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    // Per-cycle commands broadcast along the cell row.
    typedef struct packed {
        logic shift;   // shift a stream byte into the window
        logic clear;   // clear the window
        logic load;    // write one pattern byte
        logic rotate;  // rotate the pattern row by one cell
    } t_row_ctl;

    // Control carried beside the compare results down the pipeline.
    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [LEN_W-1:0] len;
    } t_stage;

endpackage

/* src/poc_ifs.sv */
// Input channel: one operation word per handshake.
interface poc_item_if;
    import poc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [BYTE_W-1:0]    data_byte;
    logic [INDEX_W-1:0]   pattern_index;

    modport source (output valid, output operation, output data_byte,
                    output pattern_index, input ready);
    modport sink   (input valid, input operation, input data_byte,
                    input pattern_index, output ready);
endinterface

// Result channel: one result word per input word.
interface poc_result_if;
    import poc_pkg::*;

    logic               valid;
    logic               ready;
    logic               match_found;
    logic [COUNT_W-1:0] occurrence_count;

    modport source (output valid, output match_found, output occurrence_count,
                    input ready);
    modport sink   (input valid, input match_found, input occurrence_count,
                    output ready);
endinterface

// Configuration channel: writes the pattern length register.
interface poc_cfg_if;
    import poc_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] pattern_length;

    modport source (output valid, output pattern_length, input ready);
    modport sink   (input valid, input pattern_length, output ready);
endinterface

/* src/poc_cell.sv */
module poc_cell #(
    parameter int unsigned IDX_W = 8,
    parameter int unsigned INDEX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  poc_pkg::t_row_ctl             i_ctl,
    input  logic [IDX_W-1:0]              i_slot,
    input  logic [poc_pkg::BYTE_W-1:0]    i_data,
    input  logic [poc_pkg::LEN_W-1:0]     i_len,
    input  logic [poc_pkg::BYTE_W-1:0]    i_win_prev,
    input  logic [poc_pkg::BYTE_W-1:0]    i_pat_prev,
    output logic [poc_pkg::BYTE_W-1:0]    o_win,
    output logic [poc_pkg::BYTE_W-1:0]    o_pat,
    output logic                          o_eq
);
    import poc_pkg::*;

    logic [BYTE_W-1:0] r_win;
    logic [BYTE_W-1:0] r_pat;
    logic              r_eq;
    logic              n_eq;
    logic              slot_hit;

    assign slot_hit = (i_slot == IDX_W'(INDEX));

    // A cell beyond the pattern length always agrees; otherwise compare the
    // byte arriving in this window cell with the pattern byte aligned here.
    assign n_eq = (INDEX >= int'(i_len)) || (i_win_prev == r_pat);

    // Window byte: one tap of the shift line of stream bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_ctl.clear) begin
            r_win <= '0;
        end else if (i_ctl.shift) begin
            r_win <= i_win_prev;
        end
    end

    // Pattern byte: written by a load aimed at this cell, or rotated along.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && slot_hit) begin
            r_pat <= i_data;
        end else if (i_ctl.rotate) begin
            r_pat <= i_pat_prev;
        end
    end

    // Compare result for the stream byte being shifted in.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_eq <= n_eq;
        end
    end

    assign o_win = r_win;
    assign o_pat = r_pat;
    assign o_eq  = r_eq;

endmodule

/* src/poc_row.sv */
module poc_row #(
    parameter int unsigned MAX_PATTERN = poc_pkg::MAX_PATTERN_DEF,
    parameter int unsigned IDX_W       = $clog2(MAX_PATTERN),
    parameter int unsigned GROUPS      =
        (MAX_PATTERN + poc_pkg::GROUP_SIZE - 1) / poc_pkg::GROUP_SIZE
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  poc_pkg::t_row_ctl          i_ctl,
    input  logic [IDX_W-1:0]           i_slot,
    input  logic [poc_pkg::BYTE_W-1:0] i_data,
    input  logic [poc_pkg::LEN_W-1:0]  i_len,
    input  logic                       i_advance,
    output logic [GROUPS-1:0]          o_grp
);
    import poc_pkg::*;

    localparam int unsigned PAD_W = GROUPS * GROUP_SIZE;

    logic [BYTE_W-1:0] win [MAX_PATTERN];
    logic [BYTE_W-1:0] pat [MAX_PATTERN];
    logic [PAD_W-1:0]  eq_pad;
    logic [GROUPS-1:0] r_grp;

    // Chain of cells: the window shifts from cell 0 upwards, the pattern
    // row rotates upwards with the last cell feeding cell 0.
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic [BYTE_W-1:0] win_prev;
        logic [BYTE_W-1:0] pat_prev;

        if (j == 0) begin : g_head
            assign win_prev = i_data;
            assign pat_prev = pat[MAX_PATTERN-1];
        end else begin : g_body
            assign win_prev = win[j-1];
            assign pat_prev = pat[j-1];
        end

        poc_cell #(
            .IDX_W (IDX_W),
            .INDEX (j)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_slot     (i_slot),
            .i_data     (i_data),
            .i_len      (i_len),
            .i_win_prev (win_prev),
            .i_pat_prev (pat_prev),
            .o_win      (win[j]),
            .o_pat      (pat[j]),
            .o_eq       (eq_pad[j])
        );
    end

    // Padding bits past the last cell always agree.
    if (PAD_W > MAX_PATTERN) begin : g_pad
        assign eq_pad[PAD_W-1:MAX_PATTERN] = '1;
    end

    // First level of the match tree: one register per group of cells.
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int g = 0; g < int'(GROUPS); g++) begin
                r_grp[g] <= &eq_pad[g*GROUP_SIZE +: GROUP_SIZE];
            end
        end
    end

    assign o_grp = r_grp;

endmodule

/* src/poc_tally.sv */
module poc_tally #(
    parameter int unsigned GROUPS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  poc_pkg::t_stage             i_stage,
    input  logic [GROUPS-1:0]           i_grp,
    input  logic                        i_ready,
    output logic                        o_advance,
    output logic                        o_valid,
    output logic                        o_match_found,
    output logic [poc_pkg::COUNT_W-1:0] o_occurrence_count
);
    import poc_pkg::*;

    logic               r_valid;
    logic               r_found;
    logic [COUNT_W-1:0] r_total;
    logic [LEN_W-1:0]   r_since;
    logic               n_found;
    logic [COUNT_W-1:0] n_total;
    logic [LEN_W-1:0]   n_since;
    logic [LEN_W-1:0]   since_inc;
    logic               all_eq;

    // The whole pipeline moves when the output register is free or taken.
    assign o_advance = !r_valid || i_ready;

    assign all_eq    = &i_grp;
    assign since_inc = (r_since == SINCE_MAX) ? r_since : r_since + LEN_W'(1);

    // Counting of non-overlapping occurrences and the saturating total.
    always_comb begin
        n_found = 1'b0;
        n_total = r_total;
        n_since = r_since;
        case (i_stage.op)
            OP_SEARCH: begin
                n_since = since_inc;
                if ((since_inc >= i_stage.len) && all_eq) begin
                    n_found = 1'b1;
                    n_since = '0;
                    if (r_total != TOTAL_MAX) begin
                        n_total = r_total + COUNT_W'(1);
                    end
                end
            end
            OP_RESTART: begin
                n_since = '0;
                n_total = '0;
            end
            default: begin
                n_found = 1'b0;
            end
        endcase
    end

    // Search state and output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_total <= '0;
            r_since <= '0;
        end else if (o_advance) begin
            r_valid <= i_stage.valid;
            if (i_stage.valid) begin
                r_total <= n_total;
                r_since <= n_since;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_stage.valid) begin
            r_found <= n_found;
        end
    end

    assign o_valid            = r_valid;
    assign o_match_found      = r_found;
    assign o_occurrence_count = r_total;

endmodule

/* src/pattern_occurrence_counter.sv */
// Counts non-overlapping occurrences of a stored byte pattern in a byte
// stream and returns one result word for every input word. Pattern bytes are
// loaded by index; a search word shifts its byte into a row of cells, each of
// which holds one window byte and one pattern byte and compares them, so that
// an occurrence of up to MAX_PATTERN bytes is checked in a single pass. The
// block takes one word per cycle while not stalled or aligning, and registers
// each result in the cell compare, group register and output register stages;
// back-pressure on the result channel stalls the whole pipeline. Pattern bytes
// sit in the row aligned to the current pattern length, so after a length
// write the row rotates by one cell per cycle until aligned again, and input
// is held off while it rotates. Pattern bytes that were never loaded have no
// defined value, and a search that compares against them gives no defined
// result.
module pattern_occurrence_counter #(
    parameter int unsigned MAX_PATTERN = poc_pkg::MAX_PATTERN_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    poc_item_if.sink     i_item,
    poc_cfg_if.sink      i_cfg,
    poc_result_if.source o_result
);
    import poc_pkg::*;

    localparam int unsigned IDX_W  = $clog2(MAX_PATTERN);
    localparam int unsigned SUM_W  = IDX_W + 1;
    localparam int unsigned GROUPS = (MAX_PATTERN + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [LEN_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_align;
    t_stage            r_s1;
    t_stage            r_s2;
    logic [LEN_W-1:0]  eff_len;
    logic [IDX_W-1:0]  target;
    logic              aligned;
    logic              advance;
    logic              accept;
    t_op               op;
    logic              index_ok;
    logic [SUM_W-1:0]  slot_sum;
    logic [IDX_W-1:0]  slot;
    t_row_ctl          row_ctl;
    logic [GROUPS-1:0] grp;

    // Length register; writes are taken in any cycle outside reset.
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
        end else if (i_cfg.valid) begin
            r_len <= i_cfg.pattern_length;
        end
    end

    // Length in use: zero acts as one, and it never exceeds the row.
    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(r_len) > 32'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = r_len;
        end
    end

    // Pattern byte k sits in cell (align - 1 - k) mod MAX_PATTERN; the row is
    // aligned when align equals the length in use, modulo the row depth.
    assign target  = (32'(eff_len) == 32'(MAX_PATTERN)) ? '0 : IDX_W'(eff_len);
    assign aligned = (r_align == target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= IDX_W'(1);
        end else if (!aligned) begin
            r_align <= (32'(r_align) == MAX_PATTERN - 1) ? '0 : r_align + IDX_W'(1);
        end
    end

    // Input handshake.
    assign i_item.ready = i_rst_n && advance && aligned;
    assign accept       = i_item.valid && i_item.ready;
    assign op           = t_op'(i_item.operation);
    assign index_ok     = (32'(i_item.pattern_index) < 32'(MAX_PATTERN));

    // Cell that receives a loaded pattern byte.
    assign slot_sum = {1'b0, r_align} + SUM_W'(MAX_PATTERN - 1)
                    - SUM_W'(i_item.pattern_index);
    assign slot     = (32'(slot_sum) >= 32'(MAX_PATTERN))
                    ? IDX_W'(slot_sum - SUM_W'(MAX_PATTERN))
                    : slot_sum[IDX_W-1:0];

    // Commands along the cell row.
    always_comb begin
        row_ctl        = '0;
        row_ctl.rotate = !aligned;
        if (accept) begin
            case (op)
                OP_LOAD:    row_ctl.load  = index_ok;
                OP_SEARCH:  row_ctl.shift = 1'b1;
                OP_RESTART: row_ctl.clear = 1'b1;
                default:    row_ctl.shift = 1'b0;
            endcase
        end
    end

    poc_row #(
        .MAX_PATTERN (MAX_PATTERN),
        .IDX_W       (IDX_W),
        .GROUPS      (GROUPS)
    ) u_row (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (row_ctl),
        .i_slot    (slot),
        .i_data    (i_item.data_byte),
        .i_len     (eff_len),
        .i_advance (advance),
        .o_grp     (grp)
    );

    // Control words following the compare results through the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (advance) begin
            r_s1.valid <= accept;
            r_s1.op    <= op;
            r_s1.len   <= eff_len;
            r_s2       <= r_s1;
        end
    end

    poc_tally #(
        .GROUPS (GROUPS)
    ) u_tally (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_stage            (r_s2),
        .i_grp              (grp),
        .i_ready            (o_result.ready),
        .o_advance          (advance),
        .o_valid            (o_result.valid),
        .o_match_found      (o_result.match_found),
        .o_occurrence_count (o_result.occurrence_count)
    );

endmodule
